// ===== hdl/jhfc_pkg.sv =====
// ----------------------------------------------------------------------------
// jhfc_pkg: shared types and constants of the hours and fault collector
// Request and result formats, status codes, token kinds and the fault table
// geometry used by the cell chain and the top level.
// ----------------------------------------------------------------------------
package jhfc_pkg;

	// fault table geometry
	localparam int FAULT_SLOTS = 8;
	localparam int SLOT_W      = (FAULT_SLOTS > 1) ? $clog2(FAULT_SLOTS) : 1;
	localparam int USED_W      = $clog2(FAULT_SLOTS + 1);

	// field widths
	localparam int PGN_W   = 18;
	localparam int CODE_W  = 19;
	localparam int MODE_W  = 5;
	localparam int HOURS_W = 32;
	localparam int CFG_IDX_W = 1;

	// request types
	localparam logic [1:0] REQ_FRAME  = 2'd0;
	localparam logic [1:0] REQ_REPORT = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HOURS_PGN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAULT_PGN = 1'd1;

	// configuration reset values
	localparam logic [PGN_W-1:0] HOURS_PGN_RST = 18'd65253;
	localparam logic [PGN_W-1:0] FAULT_PGN_RST = 18'd65226;

	// result status codes
	localparam logic [3:0] ST_IGNORED     = 4'd0;
	localparam logic [3:0] ST_HOURS_STORE = 4'd1;
	localparam logic [3:0] ST_SHORT       = 4'd2;
	localparam logic [3:0] ST_UNAVAIL     = 4'd3;
	localparam logic [3:0] ST_FAULT_ADD   = 4'd4;
	localparam logic [3:0] ST_FAULT_KNOWN = 4'd5;
	localparam logic [3:0] ST_TABLE_FULL  = 4'd6;
	localparam logic [3:0] ST_NO_CODE     = 4'd7;
	localparam logic [3:0] ST_HOURS_REC   = 4'd8;
	localparam logic [3:0] ST_FAULT_REC   = 4'd9;
	localparam logic [3:0] ST_CLEARED     = 4'd10;

	// token kinds travelling down the cell chain
	localparam logic [1:0] TK_DONE   = 2'd0;
	localparam logic [1:0] TK_PROBE  = 2'd1;
	localparam logic [1:0] TK_REPORT = 2'd2;

	// input request
	typedef struct packed {
		logic [1:0]  req_type;
		logic        is_extended;
		logic [28:0] can_id;
		logic [3:0]  byte_count;
		logic [63:0] payload;
	} req_t;

	// result item
	typedef struct packed {
		logic [3:0]         status;
		logic               hours_fresh;
		logic [HOURS_W-1:0] hours_count;
		logic [CODE_W-1:0]  fault_code;
		logic [MODE_W-1:0]  fault_mode;
		logic [2:0]         slot_index;
		logic               last;
	} rsp_t;

	// token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic [1:0]        kind;
		logic [3:0]        status;
		logic [CODE_W-1:0] code;
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] idx;
		logic              hit;
		logic              last;
	} token_t;

	// table write command
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] idx;
		logic [CODE_W-1:0] code;
		logic [MODE_W-1:0] mode;
	} tbl_wr_t;

endpackage

// ===== hdl/j1939_hours_and_fault_collector_unit.sv =====
// ----------------------------------------------------------------------------
// j1939_hours_and_fault_collector_unit: engine hours and active fault collector
// Decodes received frames, keeps the hours count and a deduplicated fault
// table in a chain of slot cells, and answers report and clear requests.
// Each token walks the whole cell chain, registered in every slot cell, before
// its result enters the output register.
// Throughput: a report gives 1 + slots_used results, one per cycle while the
// output does not stall; any other request gives one. The next request is taken
// only after the final result has entered the output register, and only while
// the output is not stalled. Output stall freezes the chain.
// Reset: clears hours, fresh flag, table fill count, the chain and restores
// the PGN registers; table entries are not cleared.
// ----------------------------------------------------------------------------
module j1939_hours_and_fault_collector_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  jhfc_pkg::req_t                 in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output jhfc_pkg::rsp_t                 out_data,
	input  logic                           cfg_wr_en,
	input  logic [jhfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jhfc_pkg::PGN_W-1:0]     cfg_data
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_INJECT = 2'd1;
	localparam logic [1:0] S_WAIT   = 2'd2;

	logic [1:0]                      state_q;
	logic [jhfc_pkg::SLOT_W-1:0]     cnt_q;
	logic [jhfc_pkg::PGN_W-1:0]      hours_pgn_q;
	logic [jhfc_pkg::PGN_W-1:0]      fault_pgn_q;
	logic [jhfc_pkg::HOURS_W-1:0]    hours_q;
	logic                            fresh_q;
	logic [jhfc_pkg::USED_W-1:0]     used_q;
	logic                            out_valid_q;
	jhfc_pkg::rsp_t                  out_q;

	logic                            adv;
	logic                            accept;
	logic [jhfc_pkg::PGN_W-1:0]      pgn;
	logic [7:0]                      b0;
	logic [7:0]                      b1;
	logic [7:0]                      b2;
	logic                            hours_ok;
	logic                            table_full;
	logic                            rpt_last;
	jhfc_pkg::token_t                dec_tok;
	jhfc_pkg::token_t                tok [0:jhfc_pkg::FAULT_SLOTS];
	jhfc_pkg::token_t                tail;
	jhfc_pkg::rsp_t                  rsp;
	jhfc_pkg::tbl_wr_t               wr;
	logic [jhfc_pkg::FAULT_SLOTS-1:0] occ;

	// chain moves when the output register can take a result
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !adv;
	assign accept   = in_valid && !in_stall;

	// frame field extraction
	assign pgn = in_data.can_id[25:8];
	assign b0  = in_data.payload[23:16];
	assign b1  = in_data.payload[31:24];
	assign b2  = in_data.payload[39:32];
	assign hours_ok = (in_data.req_type == jhfc_pkg::REQ_FRAME) && in_data.is_extended &&
		(pgn == hours_pgn_q) && (in_data.byte_count >= 4'd4) &&
		(in_data.payload[31:0] != 32'hFFFF_FFFF);

	// request decode into the first token
	always_comb begin
		dec_tok        = '0;
		dec_tok.valid  = 1'b1;
		dec_tok.kind   = jhfc_pkg::TK_DONE;
		dec_tok.status = jhfc_pkg::ST_IGNORED;
		dec_tok.last   = 1'b1;
		case (in_data.req_type)
			jhfc_pkg::REQ_FRAME: begin
				if (!in_data.is_extended) begin
					dec_tok.status = jhfc_pkg::ST_IGNORED;
				end else if (pgn == hours_pgn_q) begin
					if (in_data.byte_count < 4'd4) begin
						dec_tok.status = jhfc_pkg::ST_SHORT;
					end else if (in_data.payload[31:0] == 32'hFFFF_FFFF) begin
						dec_tok.status = jhfc_pkg::ST_UNAVAIL;
					end else begin
						dec_tok.status = jhfc_pkg::ST_HOURS_STORE;
					end
				end else if (pgn == fault_pgn_q) begin
					if (in_data.byte_count < 4'd6) begin
						dec_tok.status = jhfc_pkg::ST_SHORT;
					end else if ((b0 == 8'hFF) && (b1 == 8'hFF) && (b2 == 8'hFF)) begin
						dec_tok.status = jhfc_pkg::ST_NO_CODE;
					end else begin
						dec_tok.kind = jhfc_pkg::TK_PROBE;
						dec_tok.code = {b2[7:5], b1, b0};
						dec_tok.mode = b2[4:0];
					end
				end
			end
			jhfc_pkg::REQ_REPORT: begin
				dec_tok.status = jhfc_pkg::ST_HOURS_REC;
				dec_tok.last   = (used_q == '0);
			end
			jhfc_pkg::REQ_CLEAR: begin
				dec_tok.status = jhfc_pkg::ST_CLEARED;
			end
			default: begin
				dec_tok.status = jhfc_pkg::ST_IGNORED;
			end
		endcase
	end

	// report token for the slot under the counter
	assign rpt_last = ((jhfc_pkg::USED_W'(cnt_q) + jhfc_pkg::USED_W'(1)) == used_q);

	// chain input
	always_comb begin
		tok[0] = '0;
		case (state_q)
			S_IDLE: begin
				tok[0]       = dec_tok;
				tok[0].valid = accept;
			end
			S_INJECT: begin
				tok[0].valid = 1'b1;
				tok[0].kind  = jhfc_pkg::TK_REPORT;
				tok[0].idx   = cnt_q;
				tok[0].last  = rpt_last;
			end
			default: begin
				tok[0] = '0;
			end
		endcase
	end

	// row of slot cells
	for (genvar i = 0; i < jhfc_pkg::FAULT_SLOTS; i++) begin : g_cell
		assign occ[i] = (jhfc_pkg::USED_W'(i) < used_q);
		jhfc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.slot_id  (jhfc_pkg::SLOT_W'(i)),
			.occupied (occ[i]),
			.wr       (wr),
			.tok_in   (tok[i]),
			.tok_out  (tok[i+1])
		);
	end

	assign tail       = tok[jhfc_pkg::FAULT_SLOTS];
	assign table_full = (used_q == jhfc_pkg::USED_W'(jhfc_pkg::FAULT_SLOTS));

	// result at the chain end
	always_comb begin
		rsp             = '0;
		rsp.hours_fresh = fresh_q;
		rsp.hours_count = hours_q;
		rsp.last        = tail.last;
		wr              = '0;
		wr.idx          = jhfc_pkg::SLOT_W'(used_q);
		wr.code         = tail.code;
		wr.mode         = tail.mode;
		case (tail.kind)
			jhfc_pkg::TK_PROBE: begin
				rsp.fault_code = tail.code;
				rsp.fault_mode = tail.mode;
				if (tail.hit) begin
					rsp.status     = jhfc_pkg::ST_FAULT_KNOWN;
					rsp.slot_index = 3'(tail.idx);
				end else if (!table_full) begin
					rsp.status     = jhfc_pkg::ST_FAULT_ADD;
					rsp.slot_index = 3'(used_q);
					wr.en          = tail.valid && adv;
				end else begin
					rsp.status     = jhfc_pkg::ST_TABLE_FULL;
				end
			end
			jhfc_pkg::TK_REPORT: begin
				rsp.status     = jhfc_pkg::ST_FAULT_REC;
				rsp.fault_code = tail.code;
				rsp.fault_mode = tail.mode;
				rsp.slot_index = 3'(tail.idx);
			end
			default: begin
				rsp.status = tail.status;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if ((in_data.req_type == jhfc_pkg::REQ_REPORT) && (used_q != '0)) begin
							state_q <= S_INJECT;
						end else begin
							state_q <= S_WAIT;
						end
					end
				end
				S_INJECT: begin
					if (adv) begin
						cnt_q <= cnt_q + 1'b1;
						if (rpt_last) begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (adv && tail.valid && tail.last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// configuration, hours and table fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_pgn_q <= jhfc_pkg::HOURS_PGN_RST;
			fault_pgn_q <= jhfc_pkg::FAULT_PGN_RST;
			hours_q     <= '0;
			fresh_q     <= 1'b0;
			used_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					jhfc_pkg::CFG_HOURS_PGN: hours_pgn_q <= cfg_data;
					jhfc_pkg::CFG_FAULT_PGN: fault_pgn_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept && hours_ok) begin
				hours_q <= in_data.payload[31:0];
				fresh_q <= 1'b1;
			end
			if (accept && (in_data.req_type == jhfc_pkg::REQ_CLEAR)) begin
				fresh_q <= 1'b0;
				used_q  <= '0;
			end
			if (wr.en) begin
				used_q <= used_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tail.valid) begin
			out_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== hdl/jhfc_cell.sv =====
// ----------------------------------------------------------------------------
// jhfc_cell: one fault table slot in the cell chain
// Holds one code and mode, marks a probe token that matches, fills a report
// token addressed to this slot and passes the token on every advance.
// ----------------------------------------------------------------------------
module jhfc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [jhfc_pkg::SLOT_W-1:0] slot_id,
	input  logic                        occupied,
	input  jhfc_pkg::tbl_wr_t           wr,
	input  jhfc_pkg::token_t            tok_in,
	output jhfc_pkg::token_t            tok_out
);

	logic [jhfc_pkg::CODE_W-1:0] code_q;
	logic [jhfc_pkg::MODE_W-1:0] mode_q;
	jhfc_pkg::token_t            tok_q;
	jhfc_pkg::token_t            tok_nxt;

	// stored entry, no reset
	always_ff @(posedge clk) begin
		if (wr.en && (wr.idx == slot_id)) begin
			code_q <= wr.code;
			mode_q <= wr.mode;
		end
	end

	// match a probe, fill a report
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && (tok_in.kind == jhfc_pkg::TK_PROBE) && occupied &&
				!tok_in.hit && (code_q == tok_in.code) && (mode_q == tok_in.mode)) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.idx = slot_id;
		end
		if (tok_in.valid && (tok_in.kind == jhfc_pkg::TK_REPORT) &&
				(tok_in.idx == slot_id)) begin
			tok_nxt.code = code_q;
			tok_nxt.mode = mode_q;
		end
	end

	// hand on to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule
